>>> hdl/ipem_pkg.sv
`default_nettype none
package ipem_pkg;

  localparam int PortCount   = 8;
  localparam int UsablePorts = (PortCount < 8) ? PortCount : 8;
  localparam logic [7:0] LineMask = 8'((1 << UsablePorts) - 1);

  localparam int InDataW  = 24;
  localparam int OutDataW = 32;

  typedef enum logic {
    IrqIdle,
    IrqWait
  } irq_state_e;

  typedef struct packed {
    logic       step;
    logic       txn;
    logic       ack_any;
    logic [7:0] lines;
  } irq_req_t;

  typedef struct packed {
    logic       pending;
    logic [3:0] source;
  } irq_status_t;

endpackage
`default_nettype wire

>>> hdl/ipem_irq_ctrl.sv
`default_nettype none
module ipem_irq_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ipem_pkg::irq_req_t   req_i,
  output      ipem_pkg::irq_status_t status_o
);
  import ipem_pkg::*;

  irq_state_e state_q, state_d;
  logic [3:0] src_q, src_d;
  logic       found;
  logic [3:0] num;
  logic       capture;

  // lowest raised line wins
  always_comb begin
    found = 1'b0;
    num   = '0;
    for (int i = 7; i >= 0; i--) begin
      if (req_i.lines[i]) begin
        found = 1'b1;
        num   = 4'(i + 1);
      end
    end
  end

  assign capture = (state_q == IrqIdle) && req_i.step && !req_i.txn && found;

  always_comb begin
    state_d = state_q;
    src_d   = src_q;
    case (state_q)
      IrqIdle: begin
        if (capture) begin
          state_d = IrqWait;
          src_d   = num;
        end
      end
      IrqWait: begin
        if (req_i.step && req_i.ack_any) begin
          state_d = IrqIdle;
        end
      end
      default: state_d = IrqIdle;
    endcase
  end

  always_comb begin
    status_o.pending = (state_q == IrqWait);
    status_o.source  = src_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IrqIdle;
      src_q   <= '0;
    end else begin
      state_q <= state_d;
      src_q   <= src_d;
    end
  end

  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == IrqWait) && req_i.step && req_i.ack_any |=> state_q == IrqIdle)
    else $error("ack did not release interrupt");

  a_capture_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == IrqWait) |-> $past(req_i.step && !req_i.txn && (req_i.lines != '0)))
    else $error("interrupt raised without a request");

  a_src_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(src_q) |-> $past(state_q == IrqIdle && req_i.step))
    else $error("source number changed outside capture");

  a_src_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == IrqWait) |-> (src_q != '0) && (src_q <= 4'(UsablePorts)))
    else $error("pending interrupt with bad source number");

endmodule
`default_nettype wire

>>> hdl/ip_port_enable_and_irq_manager_top.sv
// Port enable decoder and interrupt manager.
// Slave stream: one item per clock tick of the controlled system, carrying
//   the CPU control word and the IP interrupt lines. Master stream: one
//   result item per input item, in order.
// The enable/ack one-hots are decoded from the item's own control word;
//   cpu_interrupt and irq_source_number show the controller state as left
//   by the previous items, and the state is updated as the item passes.
// An accepted item passes the input register, then the result register,
//   before it is presented on the master side.
// Throughput: one item per cycle unless the receiver stalls; one compare,
//   a 3-to-8 decode and an 8-line priority encoder lie between the registers.
// Reset clears both stream registers and the controller: idle, source
//   number zero. When the receiver stalls, the result register holds its
//   item, the input register fills, and s_axis_tready_o drops until the
//   result is taken; nothing is lost or repeated.
`default_nettype none
module ip_port_enable_and_irq_manager_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output      logic                          s_axis_tready_o,
  // [15:0] control_word, [23:16] irq_lines
  input  wire logic [ipem_pkg::InDataW-1:0]  s_axis_tdata_i,
  output      logic                          m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // [0] transaction_active, [3:1] selected_port, [4] port_valid,
  // [12:5] enable_vector, [20:13] ack_vector, [21] cpu_interrupt,
  // [25:22] irq_source_number, [26] bus_write_strobe, [31:27] zero
  output      logic [ipem_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import ipem_pkg::*;

  logic                in_valid_q, in_valid_d;
  logic [15:0]         cw_q;
  logic [7:0]          lines_q;
  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic                advance;
  logic                s_accept;

  logic        txn;
  logic        ack_bit;
  logic [11:0] idx;
  logic        valid;
  logic [7:0]  onehot;
  logic [7:0]  enab;
  logic [7:0]  ackv;
  logic        strobe;

  irq_req_t    irq_req;
  irq_status_t irq_status;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  assign txn     = cw_q[12];
  assign ack_bit = cw_q[13];
  assign idx     = cw_q[11:0] - 12'd1;
  assign valid   = (idx < 12'(UsablePorts));
  assign onehot  = valid ? (8'd1 << idx[2:0]) : 8'd0;
  assign enab    = txn ? onehot : 8'd0;
  assign ackv    = (txn && ack_bit) ? onehot : 8'd0;
  assign strobe  = irq_status.pending && !txn;

  always_comb begin
    irq_req.step    = advance;
    irq_req.txn     = txn;
    irq_req.ack_any = (ackv != 8'd0);
    irq_req.lines   = lines_q & LineMask;
  end

  ipem_irq_ctrl u_irq_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (irq_req),
    .status_o (irq_status)
  );

  assign out_data_d = {5'd0, strobe, irq_status.source, irq_status.pending,
                       ackv, enab, valid, idx[2:0], txn};

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      cw_q    <= s_axis_tdata_i[15:0];
      lines_q <= s_axis_tdata_i[23:16];
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |=> out_valid_q && $stable(out_data_q))
    else $error("stalled result overwritten");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |-> !s_axis_tready_o)
    else $error("input register accepted while occupied");

  a_enable_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_data_q[12:5] == 8'd0) || (out_data_q[0] && out_data_q[4]))
    else $error("enable without valid transaction");

endmodule
`default_nettype wire

>>> dv/tb_ip_port_enable_and_irq_manager_top.sv
`timescale 1ns / 1ps
module tb_ip_port_enable_and_irq_manager_top;

  import ipem_pkg::*;

  typedef struct packed {
    logic       bus_write_strobe;
    logic [3:0] irq_source_number;
    logic       cpu_interrupt;
    logic [7:0] ack_vector;
    logic [7:0] enable_vector;
    logic       port_valid;
    logic [2:0] selected_port;
    logic       transaction_active;
  } port_res_t;

  typedef struct {
    logic [15:0] cw;
    logic [7:0]  lines;
    bit          typed;
    port_res_t   want;
  } dir_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [InDataW-1:0]  s_data  = '0;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_data;

  irq_state_e ctl_state = IrqIdle;
  logic [3:0] src_num   = 4'd0;
  port_res_t  pending_res_q[$];
  int         mism_cnt  = 0;
  int         stall_cnt = 0;
  bit         gaps_on   = 1'b1;
  bit         hold_req  = 1'b0;

  always #4 clk_i = ~clk_i;

  ip_port_enable_and_irq_manager_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  function automatic port_res_t mk_res(logic txn, logic [2:0] sel, logic vld, logic [7:0] en,
                                       logic [7:0] ack, logic irq, logic [3:0] src,
                                       logic strobe);
    port_res_t r;
    r.transaction_active = txn;
    r.selected_port      = sel;
    r.port_valid         = vld;
    r.enable_vector      = en;
    r.ack_vector         = ack;
    r.cpu_interrupt      = irq;
    r.irq_source_number  = src;
    r.bus_write_strobe   = strobe;
    return r;
  endfunction

  // decode is combinational on the item; controller state updates after the outputs
  function automatic port_res_t predict_port_item(logic [15:0] cw, logic [7:0] lines);
    port_res_t   r;
    logic [11:0] idx;
    logic [7:0]  onehot;
    idx                  = cw[11:0] - 12'd1;
    r.transaction_active = cw[12];
    r.selected_port      = idx[2:0];
    r.port_valid         = (idx < UsablePorts);
    onehot               = r.port_valid ? (8'd1 << idx[2:0]) : 8'd0;
    r.enable_vector      = cw[12] ? onehot : 8'd0;
    r.ack_vector         = (cw[12] && cw[13]) ? onehot : 8'd0;
    r.cpu_interrupt      = (ctl_state == IrqWait);
    r.irq_source_number  = src_num;
    r.bus_write_strobe   = r.cpu_interrupt && !cw[12];
    if (ctl_state == IrqWait) begin
      if (r.ack_vector != 8'd0) ctl_state = IrqIdle;
    end else if (!cw[12]) begin
      // descending scan so the lowest raised line wins
      for (int i = UsablePorts - 1; i >= 0; i--) begin
        if (lines[i]) begin
          src_num   = 4'(i + 1);
          ctl_state = IrqWait;
        end
      end
    end
    return r;
  endfunction

  function automatic void check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      mism_cnt++;
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, fname, want, got);
    end
  endfunction

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_item(input logic [15:0] cw, input logic [7:0] lines, input bit typed,
                           input port_res_t want);
    port_res_t res;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {lines, cw};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    res = predict_port_item(cw, lines);
    pending_res_q.push_back(typed ? want : res);
    @(negedge clk_i);
  endtask

  initial begin
    forever begin
      @(negedge clk_i);
      if (!rst_ni) begin
        m_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        m_ready <= 1'b0;
        repeat (64) @(negedge clk_i);
        m_ready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
        m_ready <= 1'b1;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    port_res_t got;
    port_res_t want;
    if (rst_ni && m_valid && m_ready) begin
      got = port_res_t'(m_data[26:0]);
      if (pending_res_q.size() == 0) begin
        mism_cnt++;
        $display("%0t: unexpected result, expected none actual 0x%0h", $time, m_data);
      end else begin
        want = pending_res_q.pop_front();
        check_field("transaction_active", 32'(want.transaction_active),
                    32'(got.transaction_active));
        check_field("selected_port", 32'(want.selected_port), 32'(got.selected_port));
        check_field("port_valid", 32'(want.port_valid), 32'(got.port_valid));
        check_field("enable_vector", 32'(want.enable_vector), 32'(got.enable_vector));
        check_field("ack_vector", 32'(want.ack_vector), 32'(got.ack_vector));
        check_field("cpu_interrupt", 32'(want.cpu_interrupt), 32'(got.cpu_interrupt));
        check_field("irq_source_number", 32'(want.irq_source_number),
                    32'(got.irq_source_number));
        check_field("bus_write_strobe", 32'(want.bus_write_strobe),
                    32'(got.bus_write_strobe));
        check_field("pad bits", 32'd0, 32'(m_data[31:27]));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_valid && s_ready) || (m_valid && m_ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= 1000) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t    rows[22];
    int          kind;
    logic [15:0] cw;
    logic [7:0]  lines;

    rows[0]  = '{16'h0000, 8'h00, 1'b1,
                 mk_res(1'b0, 3'd7, 1'b0, 8'h00, 8'h00, 1'b0, 4'd0, 1'b0)};
    rows[1]  = '{16'h1001, 8'h00, 1'b1,
                 mk_res(1'b1, 3'd0, 1'b1, 8'h01, 8'h00, 1'b0, 4'd0, 1'b0)};
    rows[2]  = '{16'h1008, 8'h00, 1'b1,
                 mk_res(1'b1, 3'd7, 1'b1, 8'h80, 8'h00, 1'b0, 4'd0, 1'b0)};
    rows[3]  = '{16'h1009, 8'h00, 1'b1,
                 mk_res(1'b1, 3'd0, 1'b0, 8'h00, 8'h00, 1'b0, 4'd0, 1'b0)};
    rows[4]  = '{16'h1FFF, 8'h00, 1'b1,
                 mk_res(1'b1, 3'd6, 1'b0, 8'h00, 8'h00, 1'b0, 4'd0, 1'b0)};
    rows[5]  = '{16'h3001, 8'hFF, 1'b1,
                 mk_res(1'b1, 3'd0, 1'b1, 8'h01, 8'h01, 1'b0, 4'd0, 1'b0)};
    rows[6]  = '{16'hC000, 8'h80, 1'b0, '0};  // capture highest line
    rows[7]  = '{16'h0000, 8'h00, 1'b0, '0};
    rows[8]  = '{16'h1003, 8'h00, 1'b0, '0};  // txn masks the strobe
    rows[9]  = '{16'h3009, 8'h00, 1'b0, '0};  // ack of invalid port
    rows[10] = '{16'h2008, 8'h00, 1'b0, '0};  // ack bit without txn
    rows[11] = '{16'h3008, 8'h00, 1'b0, '0};  // release
    rows[12] = '{16'h0000, 8'h01, 1'b0, '0};
    rows[13] = '{16'h0000, 8'hFF, 1'b0, '0};
    rows[14] = '{16'h3001, 8'h00, 1'b0, '0};
    rows[15] = '{16'h0000, 8'h00, 1'b0, '0};  // source number kept after release
    rows[16] = '{16'h1000, 8'h06, 1'b0, '0};  // no capture during txn
    rows[17] = '{16'h0000, 8'h06, 1'b0, '0};
    rows[18] = '{16'hFFFF, 8'h00, 1'b0, '0};
    rows[19] = '{16'h3002, 8'h00, 1'b0, '0};
    rows[20] = '{16'h0FFF, 8'hAA, 1'b0, '0};
    rows[21] = '{16'h0000, 8'h00, 1'b0, '0};

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send_item(rows[i].cw, rows[i].lines, rows[i].typed, rows[i].want);

    s_valid <= 1'b0;
    wait (pending_res_q.size() == 0);
    @(negedge clk_i);

    for (int n = 0; n < 1100; n++) begin
      gaps_on = (n < 950);
      if (n == 300) hold_req = 1'b1;
      if (n == 600) begin
        s_valid <= 1'b0;
        wait (pending_res_q.size() == 0);
        @(negedge clk_i);
      end
      kind  = $urandom_range(0, 9);
      cw    = 16'($urandom);
      lines = 8'($urandom);
      if (kind < 4) begin
        cw[12] = 1'b0;
        if ($urandom_range(0, 1)) lines = 8'd0;
        else if ($urandom_range(0, 1)) lines = 8'd1 << $urandom_range(0, 7);
      end else if (kind < 8) begin
        cw[12] = 1'b1;
        cw[13] = ($urandom_range(0, 3) != 0);
        if (ctl_state == IrqWait && $urandom_range(0, 1)) cw[11:0] = 12'(src_num);
        else cw[11:0] = 12'($urandom_range(0, 9));
      end
      send_item(cw, lines, 1'b0, '0);
    end

    s_valid <= 1'b0;
    wait (pending_res_q.size() == 0);
    repeat (8) @(posedge clk_i);
    if (mism_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
